>>> rtl/asdc_pkg.sv
package asdc_pkg;

    // Field and register widths.
    localparam int SMP_W          = 32;
    localparam int DLT_W          = 33;
    localparam int TS_W           = 32;
    localparam int PAY_W          = 33;
    localparam int SLOPE_W        = 40;
    localparam int GAIN_W         = 16;
    localparam int GAIN_FRAC      = 8;
    localparam int WIN_CFG_W      = 6;
    localparam int THR_W          = 31;
    localparam int DVS_W          = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int TDATA_IN_W     = 32;
    localparam int TDATA_OUT_W    = 72;
    localparam int WINDOW_MAX_DEF = 32;

    // Register values after reset.
    localparam logic [WIN_CFG_W-1:0] WINDOW_SIZE_RST = 6'd32;
    localparam logic [GAIN_W-1:0]    GAIN_K_RST      = 16'd768;
    localparam logic [THR_W-1:0]     MIN_THR_RST     = 31'd65536;

    // Saturated slope codes that stand for an open door.
    localparam logic signed [SLOPE_W-1:0] SLOPE_POS_INF = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic signed [SLOPE_W-1:0] SLOPE_NEG_INF = {1'b1, {(SLOPE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE   = 2'd0,
        CFG_GAIN_K        = 2'd1,
        CFG_MIN_THRESHOLD = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_FLUSH  = 1'b1
    } t_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRAP,
        S_SUM_RD,
        S_SUM_ACC,
        S_MEAN_LD,
        S_MEAN_DIV,
        S_VAR_RD,
        S_VAR_LO,
        S_VAR_HI,
        S_VAR_LD,
        S_VAR_DIV,
        S_SQRT,
        S_EPS,
        S_UP_LD,
        S_UP_DIV,
        S_LO_DIV,
        S_DECIDE,
        S_OUT
    } t_state;

endpackage

>>> rtl/adaptive_swinging_door_compressor.sv
// A flush goes straight to delivery; the first sample and a sample on the pivot's own time skip
// the door. Below two stored deltas the threshold sets the half-width; else the deltas give a
// mean, the squared deviations a variance and its root, then both door slopes are divided out.
// A repivot divides again, a window shrink adds wrap steps, and a full output register
// stalls. One transaction in work at a time, set by the shared restoring divider, the square
// root loop and the ring's single read port. Reset (synchronous, active low) keeps the ring data.
module adaptive_swinging_door_compressor
    import asdc_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Sample stream.
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [TDATA_IN_W-1:0]    s_axis_tdata,   // [31:0] sample
    input  logic                     s_axis_tuser,   // [0] req_type
    // Result stream.
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [TDATA_OUT_W-1:0]   m_axis_tdata,   // [31:0] timestamp, [64:32] payload
    output logic                     m_axis_tuser,   // [0] transmit
    // Register writes.
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [THR_W-1:0]         i_cfg_data
);

    // Widths that follow from the ring depth. The square accumulator holds the sum of
    // up to WINDOW_MAX squares of 34-bit magnitudes, rounded up to an even width so the
    // square root loop takes two bits per step.
    localparam int IDX_W   = $clog2(WINDOW_MAX);
    localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = DLT_W + IDX_W;
    localparam int MAG_W   = DLT_W + 1;
    localparam int HALF_W  = MAG_W / 2;
    localparam int HI_W    = MAG_W - HALF_W;
    localparam int PROD_W  = MAG_W + HI_W;
    localparam int ACC_RAW = 2 * MAG_W - 1 + IDX_W;
    localparam int ACC_W   = ACC_RAW + (ACC_RAW % 2);
    localparam int ROOT_W  = ACC_W / 2;
    localparam int SR_W    = ROOT_W + 2;
    localparam int EPS_W   = ROOT_W + GAIN_W - GAIN_FRAC;
    localparam int NUM_W   = EPS_W + 2;
    localparam int CNT_W   = $clog2(ACC_W + 1);
    localparam logic [NUM_W-1:0] SAT_MAG = NUM_W'(1) << (SLOPE_W - 1);

    // Configuration registers.
    logic [WIN_CFG_W-1:0] r_window;
    logic [GAIN_W-1:0]    r_gain;
    logic [THR_W-1:0]     r_min;

    // Compressor state with a defined reset.
    t_state                     r_state, n_state;
    logic [WIN_W-1:0]           r_pos, n_pos;
    logic [WIN_W-1:0]           r_fill, n_fill;
    logic                       r_first, n_first;
    logic [SMP_W-1:0]           r_prev, n_prev;
    logic [TS_W-1:0]            r_clock, n_clock;
    logic [TS_W-1:0]            r_ptime, n_ptime;
    logic [SMP_W-1:0]           r_pval, n_pval;
    logic signed [SLOPE_W-1:0]  r_upper, n_upper;
    logic signed [SLOPE_W-1:0]  r_lower, n_lower;
    logic [TS_W-1:0]            r_htime, n_htime;
    logic [SMP_W-1:0]           r_hval, n_hval;
    logic [SMP_W-1:0]           r_sent, n_sent;
    logic                       r_m_valid, n_m_valid;

    // Working registers of the item in progress.
    logic [SMP_W-1:0]           r_cur, n_cur;
    logic [TS_W-1:0]            r_t, n_t;
    logic [TS_W-1:0]            r_dt, n_dt;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic [DLT_W-1:0]           r_mean, n_mean;
    logic [MAG_W-1:0]           r_mag, n_mag;
    logic [ACC_W-1:0]           r_acc, n_acc;
    logic [ACC_W-1:0]           r_quo, n_quo;
    logic [DVS_W-1:0]           r_rem, n_rem;
    logic [DVS_W-1:0]           r_dvs, n_dvs;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_neg, n_neg;
    logic [ROOT_W-1:0]          r_root, n_root;
    logic [SR_W-1:0]            r_srem, n_srem;
    logic [EPS_W-1:0]           r_eps, n_eps;
    logic signed [SLOPE_W-1:0]  r_su, n_su;
    logic signed [SLOPE_W-1:0]  r_sl, n_sl;
    logic                       r_round2, n_round2;
    logic                       r_res_tx, n_res_tx;
    logic [TS_W-1:0]            r_res_ts, n_res_ts;
    logic [PAY_W-1:0]           r_res_pay, n_res_pay;
    logic                       r_m_tx, n_m_tx;
    logic [TS_W-1:0]            r_m_ts, n_m_ts;
    logic [PAY_W-1:0]           r_m_pay, n_m_pay;

    // Delta ring: one write port, one registered read port.
    logic [DLT_W-1:0]           r_ring [WINDOW_MAX];
    logic [DLT_W-1:0]           r_rd;
    logic                       ring_we;
    logic [DLT_W-1:0]           ring_wd;

    // Shared datapath signals.
    logic [WIN_W-1:0]           w_eff;
    logic [DVS_W:0]             div_rem2;
    logic                       div_ge;
    logic [SR_W+1:0]            sq_t;
    logic [SR_W+1:0]            sq_trial;
    logic                       sq_ge;
    logic signed [MAG_W-1:0]    rd_diff;
    logic [MAG_W-1:0]           rd_mag;
    logic [MAG_W-1:0]           mul_a;
    logic [HI_W-1:0]            mul_b;
    logic [PROD_W-1:0]          mul_p;
    logic [GAIN_W+ROOT_W-1:0]   eps_prod;
    logic [EPS_W-1:0]           eps_k;
    logic [SUM_W-1:0]           sum_mag;
    logic signed [NUM_W-1:0]    num_up, num_lo;
    logic [NUM_W-1:0]           num_up_mag, num_lo_mag;
    logic signed [SLOPE_W-1:0]  slope_q;
    logic signed [SLOPE_W-1:0]  dec_nu, dec_nl;
    logic [TS_W-1:0]            dec_dn;
    logic [DLT_W-1:0]           mean_q;
    logic                       idx_last;
    logic                       in_xact;
    logic                       out_xact;
    logic [SMP_W-1:0]           in_sample;

    // Saturating conversion of a divider quotient with its sign into a slope code.
    function automatic logic signed [SLOPE_W-1:0] sat_slope(
        input logic             neg,
        input logic [NUM_W-1:0] q
    );
        logic [NUM_W-1:0] nq;
        nq = -q;
        if (neg) begin
            sat_slope = (q >= SAT_MAG) ? SLOPE_NEG_INF : $signed(nq[SLOPE_W-1:0]);
        end else begin
            sat_slope = (q >= SAT_MAG) ? SLOPE_POS_INF : $signed(q[SLOPE_W-1:0]);
        end
    endfunction

    assign in_xact   = s_axis_tvalid && s_axis_tready;
    assign out_xact  = r_m_valid && m_axis_tready;
    assign in_sample = s_axis_tdata[SMP_W-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_tx;
    assign m_axis_tdata  = {{(TDATA_OUT_W-PAY_W-TS_W){1'b0}}, r_m_pay, r_m_ts};

    // Effective window: zero acts as one, anything past the ring depth as the depth.
    always_comb begin
        if (r_window == '0) begin
            w_eff = WIN_W'(1);
        end else if (32'(r_window) > 32'(WINDOW_MAX)) begin
            w_eff = WIN_W'(WINDOW_MAX);
        end else begin
            w_eff = WIN_W'(r_window);
        end
    end

    // One step of the restoring divider: one quotient bit per cycle, shifted in at the bottom
    // while the dividend leaves at the top.
    assign div_rem2 = {r_rem, r_quo[ACC_W-1]};
    assign div_ge   = (div_rem2 >= {1'b0, r_dvs});

    // One step of the floor square root, two radicand bits per cycle out of the same
    // shift register that held the variance quotient.
    assign sq_t     = {r_srem, r_quo[ACC_W-1:ACC_W-2]};
    assign sq_trial = (SR_W+2)'({r_root, 2'b01});
    assign sq_ge    = (sq_t >= sq_trial);

    // Deviation of a stored delta from the mean, and the shared squaring multiplier,
    // which takes the low half of the magnitude in one cycle and the high half in the next.
    assign rd_diff = $signed({r_rd[DLT_W-1], r_rd}) - $signed({r_mean[DLT_W-1], r_mean});
    assign rd_mag  = rd_diff[MAG_W-1] ? MAG_W'(-rd_diff) : MAG_W'(rd_diff);
    assign mul_a   = (r_state == S_VAR_HI) ? r_mag : rd_mag;
    assign mul_b   = (r_state == S_VAR_HI) ? r_mag[MAG_W-1:HALF_W] : HI_W'(rd_mag[HALF_W-1:0]);
    assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign eps_prod = (GAIN_W+ROOT_W)'(r_gain) * (GAIN_W+ROOT_W)'(r_root);
    assign eps_k    = eps_prod[GAIN_W+ROOT_W-1:GAIN_FRAC];

    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign mean_q  = r_quo[DLT_W-1:0];

    // Door edges seen from the pivot.
    assign num_up = $signed({{(NUM_W-SMP_W){r_cur[SMP_W-1]}}, r_cur})
                  + $signed({2'b00, r_eps})
                  - $signed({{(NUM_W-SMP_W){r_pval[SMP_W-1]}}, r_pval});
    assign num_lo = $signed({{(NUM_W-SMP_W){r_cur[SMP_W-1]}}, r_cur})
                  - $signed({2'b00, r_eps})
                  - $signed({{(NUM_W-SMP_W){r_pval[SMP_W-1]}}, r_pval});
    assign num_up_mag = num_up[NUM_W-1] ? NUM_W'(-num_up) : NUM_W'(num_up);
    assign num_lo_mag = num_lo[NUM_W-1] ? NUM_W'(-num_lo) : NUM_W'(num_lo);
    assign slope_q    = sat_slope(r_neg, r_quo[NUM_W-1:0]);

    assign dec_nu = (r_upper < r_su) ? r_upper : r_su;
    assign dec_nl = (r_lower > r_sl) ? r_lower : r_sl;
    assign dec_dn = r_t - r_htime;

    assign idx_last = (WIN_W'(r_idx) == WIN_W'(r_fill - WIN_W'(1)));

    // Sequencer: next state and every next value of the datapath.
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_fill    = r_fill;
        n_first   = r_first;
        n_prev    = r_prev;
        n_clock   = r_clock;
        n_ptime   = r_ptime;
        n_pval    = r_pval;
        n_upper   = r_upper;
        n_lower   = r_lower;
        n_htime   = r_htime;
        n_hval    = r_hval;
        n_sent    = r_sent;
        n_m_valid = out_xact ? 1'b0 : r_m_valid;
        n_cur     = r_cur;
        n_t       = r_t;
        n_dt      = r_dt;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_mean    = r_mean;
        n_mag     = r_mag;
        n_acc     = r_acc;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_root    = r_root;
        n_srem    = r_srem;
        n_eps     = r_eps;
        n_su      = r_su;
        n_sl      = r_sl;
        n_round2  = r_round2;
        n_res_tx  = r_res_tx;
        n_res_ts  = r_res_ts;
        n_res_pay = r_res_pay;
        n_m_tx    = r_m_tx;
        n_m_ts    = r_m_ts;
        n_m_pay   = r_m_pay;
        ring_we   = 1'b0;
        ring_wd   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    if (t_req'(s_axis_tuser) == REQ_FLUSH) begin
                        n_res_tx  = 1'b1;
                        n_res_ts  = r_htime;
                        n_res_pay = PAY_W'($signed({r_hval[SMP_W-1], r_hval})
                                  - $signed({r_sent[SMP_W-1], r_sent}));
                        n_sent    = r_hval;
                        n_state   = S_OUT;
                    end else begin
                        // Every sample pushes a delta and advances the sample clock.
                        ring_we  = 1'b1;
                        n_pos    = r_pos + WIN_W'(1);
                        n_fill   = (r_fill < w_eff) ? (r_fill + WIN_W'(1)) : r_fill;
                        n_clock  = r_clock + TS_W'(1);
                        n_prev   = in_sample;
                        n_cur    = in_sample;
                        n_t      = r_clock;
                        n_round2 = 1'b0;
                        n_state  = S_WRAP;
                        if (r_first) begin
                            // The first point is sent as an absolute value.
                            ring_wd   = '0;
                            n_first   = 1'b0;
                            n_ptime   = r_clock;
                            n_pval    = in_sample;
                            n_htime   = r_clock;
                            n_hval    = in_sample;
                            n_sent    = in_sample;
                            n_dt      = '0;
                            n_res_tx  = 1'b1;
                            n_res_ts  = r_clock;
                            n_res_pay = PAY_W'($signed(in_sample));
                        end else begin
                            ring_wd   = DLT_W'($signed({in_sample[SMP_W-1], in_sample})
                                      - $signed({r_prev[SMP_W-1], r_prev}));
                            n_dt      = r_clock - r_ptime;
                            n_res_tx  = 1'b0;
                            n_res_ts  = '0;
                            n_res_pay = '0;
                        end
                    end
                end
            end

            S_WRAP: begin
                // The write position wraps modulo the window, which may have shrunk.
                if (r_pos >= w_eff) begin
                    n_pos = r_pos - w_eff;
                end else if (r_dt == '0) begin
                    n_state = S_OUT;
                end else if (r_fill < WIN_W'(2)) begin
                    n_eps   = EPS_W'(r_min);
                    n_state = S_UP_LD;
                end else begin
                    n_idx   = '0;
                    n_sum   = '0;
                    n_state = S_SUM_RD;
                end
            end

            S_SUM_RD: begin
                n_state = S_SUM_ACC;
            end

            S_SUM_ACC: begin
                n_sum = r_sum + $signed({{IDX_W{r_rd[DLT_W-1]}}, r_rd});
                if (idx_last) begin
                    n_state = S_MEAN_LD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_SUM_RD;
                end
            end

            S_MEAN_LD: begin
                n_quo   = ACC_W'(sum_mag) << (ACC_W - SUM_W);
                n_rem   = '0;
                n_dvs   = DVS_W'(r_fill);
                n_cnt   = CNT_W'(SUM_W);
                n_neg   = r_sum[SUM_W-1];
                n_state = S_MEAN_DIV;
            end

            S_MEAN_DIV: begin
                if (r_cnt != '0) begin
                    n_rem = div_ge ? DVS_W'(div_rem2 - {1'b0, r_dvs}) : div_rem2[DVS_W-1:0];
                    n_quo = {r_quo[ACC_W-2:0], div_ge};
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    n_mean  = r_neg ? DLT_W'(-mean_q) : mean_q;
                    n_idx   = '0;
                    n_acc   = '0;
                    n_state = S_VAR_RD;
                end
            end

            S_VAR_RD: begin
                n_state = S_VAR_LO;
            end

            S_VAR_LO: begin
                n_acc   = r_acc + ACC_W'(mul_p);
                n_mag   = rd_mag;
                n_state = S_VAR_HI;
            end

            S_VAR_HI: begin
                n_acc = r_acc + (ACC_W'(mul_p) << HALF_W);
                if (idx_last) begin
                    n_state = S_VAR_LD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_VAR_RD;
                end
            end

            S_VAR_LD: begin
                n_quo   = r_acc;
                n_rem   = '0;
                n_dvs   = DVS_W'(r_fill - WIN_W'(1));
                n_cnt   = CNT_W'(ACC_W);
                n_state = S_VAR_DIV;
            end

            S_VAR_DIV: begin
                if (r_cnt != '0) begin
                    n_rem = div_ge ? DVS_W'(div_rem2 - {1'b0, r_dvs}) : div_rem2[DVS_W-1:0];
                    n_quo = {r_quo[ACC_W-2:0], div_ge};
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    n_root  = '0;
                    n_srem  = '0;
                    n_cnt   = CNT_W'(ROOT_W);
                    n_state = S_SQRT;
                end
            end

            S_SQRT: begin
                if (r_cnt != '0) begin
                    n_srem = sq_ge ? SR_W'(sq_t - sq_trial) : sq_t[SR_W-1:0];
                    n_root = {r_root[ROOT_W-2:0], sq_ge};
                    n_quo  = {r_quo[ACC_W-3:0], 2'b00};
                    n_cnt  = r_cnt - CNT_W'(1);
                end else begin
                    n_state = S_EPS;
                end
            end

            S_EPS: begin
                n_eps   = (eps_k > EPS_W'(r_min)) ? eps_k : EPS_W'(r_min);
                n_state = S_UP_LD;
            end

            S_UP_LD: begin
                n_quo   = ACC_W'(num_up_mag) << (ACC_W - NUM_W);
                n_rem   = '0;
                n_dvs   = r_dt;
                n_cnt   = CNT_W'(NUM_W);
                n_neg   = num_up[NUM_W-1];
                n_state = S_UP_DIV;
            end

            S_UP_DIV: begin
                if (r_cnt != '0) begin
                    n_rem = div_ge ? DVS_W'(div_rem2 - {1'b0, r_dvs}) : div_rem2[DVS_W-1:0];
                    n_quo = {r_quo[ACC_W-2:0], div_ge};
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    n_su    = slope_q;
                    n_quo   = ACC_W'(num_lo_mag) << (ACC_W - NUM_W);
                    n_rem   = '0;
                    n_cnt   = CNT_W'(NUM_W);
                    n_neg   = num_lo[NUM_W-1];
                    n_state = S_LO_DIV;
                end
            end

            S_LO_DIV: begin
                if (r_cnt != '0) begin
                    n_rem = div_ge ? DVS_W'(div_rem2 - {1'b0, r_dvs}) : div_rem2[DVS_W-1:0];
                    n_quo = {r_quo[ACC_W-2:0], div_ge};
                    n_cnt = r_cnt - CNT_W'(1);
                end else if (r_round2) begin
                    // Slopes from the new pivot replace the door outright.
                    n_upper = r_su;
                    n_lower = slope_q;
                    n_state = S_OUT;
                end else begin
                    n_sl    = slope_q;
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_htime = r_t;
                n_hval  = r_cur;
                if (dec_nu < dec_nl) begin
                    // The door has closed: report the held point and pivot on it.
                    n_res_tx  = 1'b1;
                    n_res_ts  = r_htime;
                    n_res_pay = PAY_W'($signed({r_hval[SMP_W-1], r_hval})
                              - $signed({r_sent[SMP_W-1], r_sent}));
                    n_sent    = r_hval;
                    n_ptime   = r_htime;
                    n_pval    = r_hval;
                    if (dec_dn != '0) begin
                        n_dt     = dec_dn;
                        n_round2 = 1'b1;
                        n_state  = S_UP_LD;
                    end else begin
                        n_upper = SLOPE_POS_INF;
                        n_lower = SLOPE_NEG_INF;
                        n_state = S_OUT;
                    end
                end else begin
                    n_upper = dec_nu;
                    n_lower = dec_nl;
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_tx    = r_res_tx;
                    n_m_ts    = r_res_ts;
                    n_m_pay   = r_res_pay;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers and compressor state with defined reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_SIZE_RST;
            r_gain    <= GAIN_K_RST;
            r_min     <= MIN_THR_RST;
            r_pos     <= '0;
            r_fill    <= '0;
            r_first   <= 1'b1;
            r_prev    <= '0;
            r_clock   <= '0;
            r_ptime   <= '0;
            r_pval    <= '0;
            r_upper   <= SLOPE_POS_INF;
            r_lower   <= SLOPE_NEG_INF;
            r_htime   <= '0;
            r_hval    <= '0;
            r_sent    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_WINDOW_SIZE:   r_window <= i_cfg_data[WIN_CFG_W-1:0];
                    CFG_GAIN_K:        r_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_MIN_THRESHOLD: r_min    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pos     <= n_pos;
            r_fill    <= n_fill;
            r_first   <= n_first;
            r_prev    <= n_prev;
            r_clock   <= n_clock;
            r_ptime   <= n_ptime;
            r_pval    <= n_pval;
            r_upper   <= n_upper;
            r_lower   <= n_lower;
            r_htime   <= n_htime;
            r_hval    <= n_hval;
            r_sent    <= n_sent;
            r_m_valid <= n_m_valid;
        end
    end

    // Working registers; their contents only matter inside one transaction.
    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_t       <= n_t;
        r_dt      <= n_dt;
        r_idx     <= n_idx;
        r_sum     <= n_sum;
        r_mean    <= n_mean;
        r_mag     <= n_mag;
        r_acc     <= n_acc;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_dvs     <= n_dvs;
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
        r_root    <= n_root;
        r_srem    <= n_srem;
        r_eps     <= n_eps;
        r_su      <= n_su;
        r_sl      <= n_sl;
        r_round2  <= n_round2;
        r_res_tx  <= n_res_tx;
        r_res_ts  <= n_res_ts;
        r_res_pay <= n_res_pay;
        r_m_tx    <= n_m_tx;
        r_m_ts    <= n_m_ts;
        r_m_pay   <= n_m_pay;
    end

    // Delta ring memory.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_pos[IDX_W-1:0]] <= ring_wd;
        end
        r_rd <= r_ring[r_idx];
    end

`ifndef SYNTHESIS
    // The fill count never passes the ring depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WIN_W'(WINDOW_MAX))
        else $error("delta ring fill count exceeds the ring depth");

    // The divider remainder stays below its divisor while a division runs.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEAN_DIV || r_state == S_VAR_DIV || r_state == S_UP_DIV
         || r_state == S_LO_DIV) |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    // A result only enters the output register from the delivery state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside the delivery state");

    // An accepted transaction always leaves the idle state.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start work");

    // Slope divisions only run on a nonzero distance.
    a_dt_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_LD) |-> (r_dt != '0))
        else $error("slope division started with zero distance");
`endif

endmodule

>>> bench/tb_adaptive_swinging_door_compressor.sv
module tb_adaptive_swinging_door_compressor;
    import asdc_pkg::*;

    // Cycles without any accepted transaction before the run is declared hung.
    localparam int HANG_LIMIT = 6000;
    localparam int RING_DEPTH = 32;

    typedef struct packed {
        logic        transmit;
        logic [31:0] stamp;
        logic [32:0] change;
    } t_report;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [THR_W-1:0]       i_cfg_data = '0;

    adaptive_swinging_door_compressor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] sample
        .s_axis_tuser  (s_axis_tuser),   // [0] req_type
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] timestamp, [64:32] payload
        .m_axis_tuser  (m_axis_tuser),   // [0] transmit
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the compressor: registers and door state.
    logic [WIN_CFG_W-1:0] win_reg;
    logic [GAIN_W-1:0]    gain_reg;
    logic [THR_W-1:0]     floor_reg;
    logic signed [32:0]   deltas [RING_DEPTH];
    int unsigned          wr_pos;
    int unsigned          fill_cnt;
    bit                   awaiting_first;
    longint               last_sample;
    logic [31:0]          clk_count;
    logic [31:0]          pivot_t;
    longint               pivot_v;
    longint               top_slope;
    longint               bot_slope;
    logic [31:0]          held_t;
    longint               held_v;
    longint               sent_v;

    t_report pending_reports[$];
    int      mismatches = 0;
    int      idle_count = 0;
    bit      tx_gaps_on = 1'b1;
    bit      rx_gaps_on = 1'b1;
    logic signed [31:0] level = '0;

    function automatic int unsigned window_used();
        if (win_reg == 0) return 1;
        if (win_reg > RING_DEPTH) return RING_DEPTH;
        return 32'(win_reg);
    endfunction

    // Door half-width: scaled sample standard deviation of the stored deltas,
    // bounded below by the threshold register.
    function automatic longint door_half_width();
        logic [127:0]    sq_sum;
        logic [127:0]    variance;
        longint          total;
        longint          mean;
        longint          dev;
        longint unsigned mag;
        longint unsigned root;
        longint unsigned cand;
        longint unsigned scaled;
        int              n;
        n = fill_cnt;
        if (n < 2) return longint'(floor_reg);
        total = 0;
        for (int i = 0; i < n; i++) total += longint'(deltas[i]);
        mean = total / n;
        sq_sum = '0;
        for (int i = 0; i < n; i++) begin
            dev = longint'(deltas[i]) - mean;
            mag = (dev < 0) ? -dev : dev;
            sq_sum += 128'(mag) * 128'(mag);
        end
        variance = sq_sum / 128'(n - 1);
        root = 0;
        for (int b = 40; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= variance) root = cand;
        end
        scaled = (64'(gain_reg) * root) >> GAIN_FRAC;
        return (scaled > 64'(floor_reg)) ? longint'(scaled) : longint'(floor_reg);
    endfunction

    function automatic longint door_slope(longint num, logic [31:0] dt);
        longint q;
        q = num / longint'({32'd0, dt});
        if (q > longint'(SLOPE_POS_INF)) return longint'(SLOPE_POS_INF);
        if (q < longint'(SLOPE_NEG_INF)) return longint'(SLOPE_NEG_INF);
        return q;
    endfunction

    function automatic void store_delta(longint d);
        deltas[wr_pos % RING_DEPTH] = d[32:0];
        wr_pos = (wr_pos + 1) % window_used();
        if (fill_cnt < window_used()) fill_cnt++;
    endfunction

    function automatic void reset_door();
        win_reg = WINDOW_SIZE_RST;
        gain_reg = GAIN_K_RST;
        floor_reg = MIN_THR_RST;
        wr_pos = 0;
        fill_cnt = 0;
        awaiting_first = 1'b1;
        last_sample = 0;
        clk_count = '0;
        pivot_t = '0;
        pivot_v = 0;
        top_slope = longint'(SLOPE_POS_INF);
        bot_slope = longint'(SLOPE_NEG_INF);
        held_t = '0;
        held_v = 0;
        sent_v = 0;
    endfunction

    // Advances the shadow door by one request and returns the report it causes.
    function automatic t_report compress_step(t_req kind, logic signed [31:0] smp);
        t_report r;
        longint  v;
        longint  eps;
        longint  up;
        longint  lo;
        longint  nu;
        longint  nl;
        longint  change;
        logic [31:0] t;
        logic [31:0] dt;
        r = '0;
        if (kind == REQ_FLUSH) begin
            change = held_v - sent_v;
            r = '{1'b1, held_t, change[32:0]};
            sent_v = held_v;
            return r;
        end
        v = longint'(smp);
        t = clk_count;
        if (awaiting_first) begin
            // The very first sample goes out as an absolute value.
            awaiting_first = 1'b0;
            last_sample = v;
            pivot_t = t;
            pivot_v = v;
            held_t = t;
            held_v = v;
            sent_v = v;
            store_delta(0);
            r = '{1'b1, t, v[32:0]};
        end else begin
            store_delta(v - last_sample);
            last_sample = v;
            eps = door_half_width();
            dt = t - pivot_t;
            // A zero distance to the pivot only advances the ring and the clock.
            if (dt != 0) begin
                up = door_slope(v + eps - pivot_v, dt);
                lo = door_slope(v - eps - pivot_v, dt);
                nu = (top_slope < up) ? top_slope : up;
                nl = (bot_slope > lo) ? bot_slope : lo;
                if (nu < nl) begin
                    // Door closed: report the held point and pivot on it.
                    change = held_v - sent_v;
                    r = '{1'b1, held_t, change[32:0]};
                    sent_v = held_v;
                    pivot_t = held_t;
                    pivot_v = held_v;
                    dt = t - pivot_t;
                    if (dt != 0) begin
                        top_slope = door_slope(v + eps - pivot_v, dt);
                        bot_slope = door_slope(v - eps - pivot_v, dt);
                    end else begin
                        top_slope = longint'(SLOPE_POS_INF);
                        bot_slope = longint'(SLOPE_NEG_INF);
                    end
                end else begin
                    top_slope = nu;
                    bot_slope = nl;
                end
                held_t = t;
                held_v = v;
            end
        end
        clk_count = t + 1;
        return r;
    endfunction

    // Every accepted request transaction is predicted at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            pending_reports.push_back(compress_step(t_req'(s_axis_tuser), s_axis_tdata));
    end

    // Result checker: each report transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[64:32]};
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: tx=%0b ts=%0d pay=%h",
                             got.transmit, got.stamp, got.change);
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"report mismatch: expected tx=%0b ts=%0d pay=%h, ",
                                  "got tx=%0b ts=%0d pay=%h"},
                                 want.transmit, want.stamp, want.change,
                                 got.transmit, got.stamp, got.change);
                end
            end
        end
    end

    // Receiver back-pressure in random bursts.
    always @(posedge i_clk) begin
        int hold;
        if (hold > 0) begin
            hold--;
            if (hold == 0) m_axis_tready <= 1'b1;
        end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            hold = $urandom_range(1, 12);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Hang detector: counts cycles with no transaction on either stream.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= HANG_LIMIT) begin
            $display("tb_adaptive_swinging_door_compressor: FAIL");
            $finish;
        end
    end

    // Sends one request and returns after the edge at which it is accepted.
    task automatic send_request(t_req kind, logic [31:0] smp);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stops sending and waits until every expected report has been taken. It first waits
    // on the clock so that the request accepted at the last edge is already predicted.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [THR_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_WINDOW_SIZE:   win_reg = value[WIN_CFG_W-1:0];
            CFG_GAIN_K:        gain_reg = value[GAIN_W-1:0];
            CFG_MIN_THRESHOLD: floor_reg = value;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [5:0] win, logic [15:0] gain, logic [30:0] thr);
        wait_drained();
        write_reg(CFG_WINDOW_SIZE, 31'(win));
        write_reg(CFG_GAIN_K, 31'(gain));
        write_reg(CFG_MIN_THRESHOLD, thr);
    endtask

    // Well-formed traffic is a drifting signal with noise; the rest is jumps,
    // repeats and flushes. Full-range jumps make every sample bit toggle.
    task automatic send_random();
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            send_request(REQ_FLUSH, $urandom);
            return;
        end
        if (pick < 18) level = $urandom;
        else if (pick < 70) begin
            case ($urandom_range(0, 2))
                0: span = 16;
                1: span = 65536;
                default: span = 1 << 20;
            endcase
            level = level + ($urandom_range(0, 2 * span) - span);
        end
        send_request(REQ_SAMPLE, level);
    endtask

    task automatic test_flush_before_sample();
        send_request(REQ_FLUSH, 32'hFFFF_FFFF);
        send_request(REQ_FLUSH, 32'h0);
    endtask

    // Extremes first, then enough samples to write every ring entry at the
    // full window, so that later window changes never read an unwritten entry.
    task automatic test_fill_ring();
        logic [31:0] edge_vals [6];
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000};
        foreach (edge_vals[i]) send_request(REQ_SAMPLE, edge_vals[i]);
        send_request(REQ_FLUSH, 32'h0);
        level = 0;
        for (int i = 0; i < RING_DEPTH - 6; i++) begin
            level = level + 32'sd40000;
            send_request(REQ_SAMPLE, level);
        end
        send_request(REQ_FLUSH, 32'h0);
    endtask

    task automatic test_config_extremes();
        set_config(6'd1, 16'd0, 31'd0);
        repeat (15) send_random();
        set_config(6'd63, 16'hFFFF, 31'h7FFF_FFFF);
        repeat (15) send_random();
        set_config(6'd0, 16'd1, 31'd1);
        repeat (15) send_random();
        set_config(6'd32, 16'hFFFF, 31'd0);
        repeat (15) send_random();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++) begin
            set_config(6'($urandom_range(0, 63)), 16'($urandom),
                       31'($urandom_range(0, 1 << 20)));
            if (phase == 5) begin
                // Last stretch runs with no gaps on either side.
                tx_gaps_on = 1'b0;
                rx_gaps_on = 1'b0;
            end
            for (int i = 0; i < 70; i++) begin
                if (phase == 2 && i == 35) wait_drained();
                send_random();
            end
        end
    endtask

    initial begin
        reset_door();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_flush_before_sample();
        test_fill_ring();
        test_config_extremes();
        test_random_phases();
        wait_drained();
        repeat (500) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("tb_adaptive_swinging_door_compressor: PASS");
        else
            $display("tb_adaptive_swinging_door_compressor: FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/asdc_pkg.sv
rtl/adaptive_swinging_door_compressor.sv
bench/tb_adaptive_swinging_door_compressor.sv
